// ----- hw/rtl/srb_pkg.sv -----
package srb_pkg;

  // descriptor field widths
  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned PREF_W = 8;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BUFFERED  = 2'd0,
    KIND_DUPLICATE = 2'd1,
    KIND_DROPPED   = 2'd2,
    KIND_DELIVERED = 2'd3
  } kind_e;

  // source of the ring read address
  typedef enum logic [1:0] {
    RD_NONE  = 2'd0,
    RD_SCAN  = 2'd1,
    RD_SHIFT = 2'd2,
    RD_HEAD  = 2'd3
  } rd_src_e;

  // one segment descriptor as stored in the ring
  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [LEN_W-1:0]  len;
    logic [PREF_W-1:0] pref;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic    in_load;
    logic    scan_init;
    logic    scan_step;
    rd_src_e rd_src;
    logic    shift_init;
    logic    shift_wr;
    logic    ins_wr;
    logic    pend_load_in;
    kind_e   pend_kind;
    logic    release_head;
    logic    emit;
    logic    emit_last;
  } srb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic scan_at_tail;
    logic shift_done;
    logic rd_eq_seg;
    logic rd_gt_seg;
    logic chk_ok;
    logic rd_eq_exp;
    logic out_free;
  } srb_status_t;

endpackage

// ----- hw/rtl/srb_ctrl.sv -----
module srb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  srb_pkg::srb_status_t status_i,
  output srb_pkg::srb_cmd_t    cmd_o
);
  import srb_pkg::*;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_START     = 4'd1;
  localparam logic [3:0] ST_SCAN_RD   = 4'd2;
  localparam logic [3:0] ST_SCAN_CMP  = 4'd3;
  localparam logic [3:0] ST_SHIFT_RD  = 4'd4;
  localparam logic [3:0] ST_SHIFT_WR  = 4'd5;
  localparam logic [3:0] ST_CHK_RD    = 4'd6;
  localparam logic [3:0] ST_CHK_CMP   = 4'd7;
  localparam logic [3:0] ST_EMIT_MORE = 4'd8;
  localparam logic [3:0] ST_EMIT_LAST = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.rd_src = RD_NONE;
    cmd_o.pend_kind = KIND_BUFFERED;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (status_i.full) begin
          cmd_o.pend_load_in = 1'b1;
          cmd_o.pend_kind = KIND_DROPPED;
          state_d = ST_CHK_RD;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (status_i.scan_at_tail) begin
          cmd_o.shift_init = 1'b1;
          state_d = ST_SHIFT_RD;
        end else begin
          cmd_o.rd_src = RD_SCAN;
          state_d = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (status_i.rd_eq_seg) begin
          cmd_o.pend_load_in = 1'b1;
          cmd_o.pend_kind = KIND_DUPLICATE;
          state_d = ST_CHK_RD;
        end else if (status_i.rd_gt_seg) begin
          cmd_o.shift_init = 1'b1;
          state_d = ST_SHIFT_RD;
        end else begin
          cmd_o.scan_step = 1'b1;
          state_d = ST_SCAN_RD;
        end
      end
      ST_SHIFT_RD: begin
        if (status_i.shift_done) begin
          cmd_o.ins_wr = 1'b1;
          cmd_o.pend_load_in = 1'b1;
          cmd_o.pend_kind = KIND_BUFFERED;
          state_d = ST_CHK_RD;
        end else begin
          cmd_o.rd_src = RD_SHIFT;
          state_d = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d = ST_SHIFT_RD;
      end
      ST_CHK_RD: begin
        if (status_i.chk_ok) begin
          cmd_o.rd_src = RD_HEAD;
          state_d = ST_CHK_CMP;
        end else begin
          state_d = ST_EMIT_LAST;
        end
      end
      ST_CHK_CMP: begin
        state_d = status_i.rd_eq_exp ? ST_EMIT_MORE : ST_EMIT_LAST;
      end
      ST_EMIT_MORE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.release_head = 1'b1;
          state_d = ST_CHK_RD;
        end
      end
      ST_EMIT_LAST: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/srb_datapath.sv -----
module srb_datapath #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srb_pkg::srb_cmd_t             cmd_i,
  output srb_pkg::srb_status_t          status_o,
  input  logic                          cfg_we_i,
  input  logic [srb_pkg::SEQ_W-1:0]     cfg_wdata_i,
  input  logic [srb_pkg::SEQ_W-1:0]     seg_seq_i,
  input  logic [srb_pkg::LEN_W-1:0]     seg_length_i,
  input  logic [srb_pkg::PREF_W-1:0]    payload_ref_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [srb_pkg::SEQ_W-1:0]     seq_o,
  output logic [srb_pkg::LEN_W-1:0]     length_o,
  output logic [srb_pkg::PREF_W-1:0]    ref_out_o,
  output logic                          last_o
);
  import srb_pkg::*;

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned NW = $clog2(RING_DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(RING_DEPTH - 1);

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = (p == LAST_IDX) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
    ring_prev = (p == '0) ? LAST_IDX : p - PW'(1);
  endfunction

  entry_t            mem_q [RING_DEPTH];
  entry_t            rd_q;
  entry_t            in_q;
  entry_t            pend_q;
  kind_e             pend_kind_q;
  logic [PW-1:0]     head_q, tail_q, scan_q, shift_q;
  logic [SEQ_W-1:0]  exp_q;
  logic [NW-1:0]     n_q;
  logic              out_valid_q;
  kind_e             out_kind_q;
  entry_t            out_q;
  logic              out_last_q;

  logic              rd_en, wr_en;
  logic [PW-1:0]     rd_addr, wr_addr;
  entry_t            wr_data;
  logic              out_free;

  // ring read address and write port select
  always_comb begin
    rd_en = 1'b1;
    case (cmd_i.rd_src)
      RD_SCAN:  rd_addr = scan_q;
      RD_SHIFT: rd_addr = ring_prev(shift_q);
      RD_HEAD:  rd_addr = head_q;
      default: begin
        rd_addr = head_q;
        rd_en = 1'b0;
      end
    endcase
    wr_en   = cmd_i.shift_wr | cmd_i.ins_wr;
    wr_addr = cmd_i.shift_wr ? shift_q : scan_q;
    wr_data = cmd_i.shift_wr ? rd_q : in_q;
  end

  // descriptor ring
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // input, pending result and walk pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      in_q.seq  <= seg_seq_i;
      in_q.len  <= seg_length_i;
      in_q.pref <= payload_ref_i;
    end
    if (cmd_i.pend_load_in) begin
      pend_q      <= in_q;
      pend_kind_q <= cmd_i.pend_kind;
    end else if (cmd_i.release_head) begin
      pend_q      <= rd_q;
      pend_kind_q <= KIND_DELIVERED;
    end
    if (cmd_i.scan_init) begin
      scan_q <= head_q;
    end else if (cmd_i.scan_step) begin
      scan_q <= ring_next(scan_q);
    end
    if (cmd_i.shift_init) begin
      shift_q <= tail_q;
    end else if (cmd_i.shift_wr) begin
      shift_q <= ring_prev(shift_q);
    end
    if (cmd_i.emit) begin
      out_q      <= pend_q;
      out_kind_q <= pend_kind_q;
      out_last_q <= cmd_i.emit_last;
    end
  end

  // ring pointers, expected sequence, result count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      exp_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ins_wr) begin
        tail_q <= ring_next(tail_q);
      end
      if (cfg_we_i) begin
        exp_q <= cfg_wdata_i;
      end else if (cmd_i.release_head) begin
        exp_q <= exp_q + SEQ_W'(rd_q.len);
      end
      if (cmd_i.release_head) begin
        head_q <= ring_next(head_q);
      end
      if (cmd_i.in_load) begin
        n_q <= NW'(1);
      end else if (cmd_i.release_head) begin
        n_q <= n_q + NW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // status back to the controller
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    status_o.full         = (head_q == ring_next(tail_q));
    status_o.scan_at_tail = (scan_q == tail_q);
    status_o.shift_done   = (shift_q == scan_q);
    status_o.rd_eq_seg    = (rd_q.seq == in_q.seq);
    status_o.rd_gt_seg    = (rd_q.seq > in_q.seq);
    status_o.chk_ok       = (head_q != tail_q) && (n_q < NW'(RING_DEPTH));
    status_o.rd_eq_exp    = (rd_q.seq == exp_q);
    status_o.out_free     = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign seq_o       = out_q.seq;
  assign length_o    = out_q.len;
  assign ref_out_o   = out_q.pref;
  assign last_o      = out_last_q;

endmodule

// ----- hw/rtl/segment_reorder_buffer_core.sv -----
// Receive reorder buffer: segment descriptors (sequence, length, payload reference) are kept
// in a ring sorted by sequence number, one descriptor per slot, RING_DEPTH - 1 usable slots.
// Each request yields one classification result (buffered, duplicate, or dropped when the
// ring is full) followed by in-order deliveries while the head sequence matches the expected
// sequence, which advances by each delivered length; last_o marks the final result of a
// request. The block takes one request at a time. The ring has one read and one write port,
// so the scan reads and then compares each slot in turn, and the shift for an insertion reads
// each slot and then writes it one place up; output stalls add to the time of a request.
// A start_seq write loads the expected sequence at once.
module segment_reorder_buffer_core #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [srb_pkg::SEQ_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [srb_pkg::SEQ_W-1:0]  seg_seq_i,
  input  logic [srb_pkg::LEN_W-1:0]  seg_length_i,
  input  logic [srb_pkg::PREF_W-1:0] payload_ref_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 kind_o,
  output logic [srb_pkg::SEQ_W-1:0]  seq_o,
  output logic [srb_pkg::LEN_W-1:0]  length_o,
  output logic [srb_pkg::PREF_W-1:0] ref_out_o,
  output logic                       last_o
);
  import srb_pkg::*;

  srb_cmd_t    cmd;
  srb_status_t status;

  // sequencer
  srb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // ring, pointers and result register
  srb_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .seg_seq_i     (seg_seq_i),
    .seg_length_i  (seg_length_i),
    .payload_ref_i (payload_ref_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .seq_o         (seq_o),
    .length_o      (length_o),
    .ref_out_o     (ref_out_o),
    .last_o        (last_o)
  );

endmodule
